// File: sv/im2col_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and helpers for the im2col address generator.
// Depends on nothing; every other file of the block imports it.
package im2col_pkg;

  // Widths of the walk counters and of the result fields.
  localparam int DIM_W   = 12;
  localparam int KER_W   = 4;
  localparam int CHN_W   = 10;
  localparam int BAT_W   = 6;
  localparam int CNT_W   = 48;
  localparam int SRC_W   = 40;

  // Widths of the decoded limits and of the small packed fields.
  localparam int LIM_K_W = 5;
  localparam int LIM_C_W = 11;
  localparam int LIM_B_W = 7;
  localparam int FLD_W   = 5;
  localparam int CLAMP_W = 12;

  // Configuration port.
  localparam int REG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [REG_IDX_W-1:0] REG_INPUT_SIZE  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_OUTPUT_SIZE = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_SIZE = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_STRIDE      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_PADDING     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DILATION    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CHANNELS    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_BATCH       = 3'd7;

  // Queue between the walker and the address pipeline.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Decoded geometry, sizes clamped; the user keeps it stable while a job runs.
  typedef struct packed {
    logic [DIM_W-1:0]   ih;
    logic [DIM_W-1:0]   iw;
    logic [DIM_W-1:0]   oh;
    logic [DIM_W-1:0]   ow;
    logic [LIM_K_W-1:0] kh;
    logic [LIM_K_W-1:0] kw;
    logic [LIM_C_W-1:0] nc;
    logic [LIM_B_W-1:0] nb;
    logic [FLD_W-1:0]   sv;
    logic [FLD_W-1:0]   sh;
    logic [FLD_W-1:0]   pt;
    logic [FLD_W-1:0]   pl;
    logic [FLD_W-1:0]   dv;
    logic [FLD_W-1:0]   dh;
  } geom_t;

  // One position of the walk, as handed from the walker to the address pipeline.
  typedef struct packed {
    logic [BAT_W-1:0] batch_pos;
    logic [DIM_W-1:0] out_row;
    logic [DIM_W-1:0] out_col;
    logic [CHN_W-1:0] channel_pos;
    logic [KER_W-1:0] kernel_row;
    logic [KER_W-1:0] kernel_col;
    logic [CNT_W-1:0] column_count;
    logic             last;
  } elem_t;

  // Zero is taken as one, anything above the maximum as the maximum.
  function automatic logic [CLAMP_W-1:0] clamp_val(input logic [CLAMP_W-1:0] v,
                                                   input logic [CLAMP_W-1:0] hi);
    logic [CLAMP_W-1:0] r;
    if (v == '0) begin
      r = CLAMP_W'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: sv/im2col_front.sv
`timescale 1ns / 1ps
// Walker: takes input beats, keeps the nested walk counters and the running
// column count, and pushes one position per beat into the queue. Uses im2col_pkg.
module im2col_front import im2col_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  geom_t geom,
  input  logic  in_valid,
  output logic  in_ready,
  input  logic  restart,
  input  logic  q_full,
  output logic  push,
  output elem_t elem
);

  logic [BAT_W-1:0] batch_pos;
  logic [DIM_W-1:0] out_row;
  logic [DIM_W-1:0] out_col;
  logic [CHN_W-1:0] channel_pos;
  logic [KER_W-1:0] kernel_row;
  logic [KER_W-1:0] kernel_col;
  logic [CNT_W-1:0] column_count;

  logic [BAT_W-1:0] cur_b;
  logic [DIM_W-1:0] cur_or;
  logic [DIM_W-1:0] cur_oc;
  logic [CHN_W-1:0] cur_ch;
  logic [KER_W-1:0] cur_kr;
  logic [KER_W-1:0] cur_kc;
  logic [CNT_W-1:0] cur_cc;

  logic [BAT_W:0] b_inc;
  logic [DIM_W:0] or_inc;
  logic [DIM_W:0] oc_inc;
  logic [CHN_W:0] ch_inc;
  logic [KER_W:0] kr_inc;
  logic [KER_W:0] kc_inc;
  logic b_wrap, or_wrap, oc_wrap, ch_wrap, kr_wrap, kc_wrap, last;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  // A restart beat is emitted from the first position of the walk.
  always_comb begin
    cur_b  = restart ? '0 : batch_pos;
    cur_or = restart ? '0 : out_row;
    cur_oc = restart ? '0 : out_col;
    cur_ch = restart ? '0 : channel_pos;
    cur_kr = restart ? '0 : kernel_row;
    cur_kc = restart ? '0 : kernel_col;
    cur_cc = restart ? '0 : column_count;

    b_inc  = {1'b0, cur_b} + (BAT_W+1)'(1);
    or_inc = {1'b0, cur_or} + (DIM_W+1)'(1);
    oc_inc = {1'b0, cur_oc} + (DIM_W+1)'(1);
    ch_inc = {1'b0, cur_ch} + (CHN_W+1)'(1);
    kr_inc = {1'b0, cur_kr} + (KER_W+1)'(1);
    kc_inc = {1'b0, cur_kc} + (KER_W+1)'(1);

    b_wrap  = b_inc >= geom.nb;
    or_wrap = or_inc >= {1'b0, geom.oh};
    oc_wrap = oc_inc >= {1'b0, geom.ow};
    ch_wrap = ch_inc >= geom.nc;
    kr_wrap = kr_inc >= geom.kh;
    kc_wrap = kc_inc >= geom.kw;
    last    = b_wrap && or_wrap && oc_wrap && ch_wrap && kr_wrap && kc_wrap;

    elem.batch_pos    = cur_b;
    elem.out_row      = cur_or;
    elem.out_col      = cur_oc;
    elem.channel_pos  = cur_ch;
    elem.kernel_row   = cur_kr;
    elem.kernel_col   = cur_kc;
    elem.column_count = cur_cc;
    elem.last         = last;
  end

  // Counters carry from the kernel column outward; the last element wraps the walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      batch_pos    <= '0;
      out_row      <= '0;
      out_col      <= '0;
      channel_pos  <= '0;
      kernel_row   <= '0;
      kernel_col   <= '0;
      column_count <= '0;
    end else if (push) begin
      if (last) begin
        batch_pos    <= '0;
        out_row      <= '0;
        out_col      <= '0;
        channel_pos  <= '0;
        kernel_row   <= '0;
        kernel_col   <= '0;
        column_count <= '0;
      end else begin
        column_count <= cur_cc + CNT_W'(1);
        kernel_col   <= kc_wrap ? '0 : kc_inc[KER_W-1:0];
        kernel_row   <= !kc_wrap ? cur_kr : (kr_wrap ? '0 : kr_inc[KER_W-1:0]);
        channel_pos  <= !(kc_wrap && kr_wrap) ? cur_ch :
                        (ch_wrap ? '0 : ch_inc[CHN_W-1:0]);
        out_col      <= !(kc_wrap && kr_wrap && ch_wrap) ? cur_oc :
                        (oc_wrap ? '0 : oc_inc[DIM_W-1:0]);
        out_row      <= !(kc_wrap && kr_wrap && ch_wrap && oc_wrap) ? cur_or :
                        (or_wrap ? '0 : or_inc[DIM_W-1:0]);
        batch_pos    <= !(kc_wrap && kr_wrap && ch_wrap && oc_wrap && or_wrap) ? cur_b :
                        (b_wrap ? '0 : b_inc[BAT_W-1:0]);
      end
    end
  end

endmodule

// File: sv/im2col_queue.sv
`timescale 1ns / 1ps
// Short first-in first-out queue of walk positions between the walker and the
// address pipeline. Uses im2col_pkg.
module im2col_queue import im2col_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  elem_t din,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output elem_t dout
);

  elem_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid = count != '0;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

endmodule

// File: sv/im2col_back.sv
`timescale 1ns / 1ps
// Address pipeline: four stages that turn a walk position into the image position,
// the padding flag and the linear source index. Uses im2col_pkg.
module im2col_back import im2col_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  geom_t            geom,
  input  logic             q_valid,
  input  elem_t            q_data,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SRC_W-1:0] source_index,
  output logic             is_padding,
  output logic [CNT_W-1:0] column_index,
  output logic             last
);

  localparam int PR_W  = DIM_W + FLD_W;
  localparam int PK_W  = KER_W + FLD_W;
  localparam int BC_W  = BAT_W + LIM_C_W;
  localparam int BCC_W = BC_W + 1;
  localparam int ROW_W = PR_W + 2;
  localparam int T_W   = BCC_W + DIM_W + 1;
  localparam int S_W   = T_W + DIM_W;

  logic advance;

  // Stage 1: partial products.
  logic             v1;
  logic [PR_W-1:0]  prv1, prh1;
  logic [PK_W-1:0]  pkv1, pkh1;
  logic [BC_W-1:0]  bc1;
  logic [CHN_W-1:0] ch1;
  logic [CNT_W-1:0] cc1;
  logic             last1;

  // Stage 2: signed image position, padding test, batch-channel plane.
  logic             v2;
  logic [ROW_W-1:0] row2, col2;
  logic             pad2;
  logic [BCC_W-1:0] bcc2;
  logic [CNT_W-1:0] cc2;
  logic             last2;
  logic [ROW_W-1:0] row_c, col_c;
  logic             pad_c;

  // Stage 3: row-linear index.
  logic             v3;
  logic [T_W-1:0]   t3;
  logic [DIM_W-1:0] col3;
  logic             pad3;
  logic [CNT_W-1:0] cc3;
  logic             last3;
  logic [T_W-1:0]   t_c;

  // Stage 4: result register.
  logic             v4;
  logic [S_W-1:0]   s_c;

  // The whole pipeline holds while a result waits at the output.
  assign advance = !v4 || out_ready;
  assign q_pop   = advance && q_valid;

  always_comb begin
    // Both sums are non-negative before the padding offset comes off, so the sign
    // bit of the extra headroom marks positions above or left of the image.
    row_c = ROW_W'(prv1) + ROW_W'(pkv1) - ROW_W'(geom.pt);
    col_c = ROW_W'(prh1) + ROW_W'(pkh1) - ROW_W'(geom.pl);
    pad_c = row_c[ROW_W-1] || (row_c[ROW_W-2:0] >= (ROW_W-1)'(geom.ih)) ||
            col_c[ROW_W-1] || (col_c[ROW_W-2:0] >= (ROW_W-1)'(geom.iw));
    t_c   = T_W'(bcc2) * T_W'(geom.ih) + T_W'(row2[DIM_W-1:0]);
    s_c   = S_W'(t3) * S_W'(geom.iw) + S_W'(col3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= q_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prv1  <= PR_W'(q_data.out_row) * PR_W'(geom.sv);
      prh1  <= PR_W'(q_data.out_col) * PR_W'(geom.sh);
      pkv1  <= PK_W'(q_data.kernel_row) * PK_W'(geom.dv);
      pkh1  <= PK_W'(q_data.kernel_col) * PK_W'(geom.dh);
      bc1   <= BC_W'(q_data.batch_pos) * BC_W'(geom.nc);
      ch1   <= q_data.channel_pos;
      cc1   <= q_data.column_count;
      last1 <= q_data.last;

      row2  <= row_c;
      col2  <= col_c;
      pad2  <= pad_c;
      bcc2  <= BCC_W'(bc1) + BCC_W'(ch1);
      cc2   <= cc1;
      last2 <= last1;

      t3    <= t_c;
      col3  <= col2[DIM_W-1:0];
      pad3  <= pad2;
      cc3   <= cc2;
      last3 <= last2;

      source_index <= pad3 ? '0 : s_c[SRC_W-1:0];
      is_padding   <= pad3;
      column_index <= cc3;
      last         <= last3;
    end
  end

  assign out_valid = v4;

endmodule

// File: sv/im2col_address_generator_core.sv
`timescale 1ns / 1ps
// im2col address generator. Each input beat either restarts the walk (restart = 1)
// or advances it by one column matrix element, and gives exactly one output beat with
// the source image index, the padding flag and the column index; tlast marks the final
// element of the job, after which the walk wraps to the start. The walker takes one
// beat per cycle into a four-entry queue while it is not full, and a four-stage address
// pipeline (three multiply levels for batch-channel, row and column) drains it, so the
// block sustains one element per cycle while the output is not stalled. Configuration
// must be written through the cfg port only while no job is in flight, which the block
// does not enforce. Sizes, channels, batch clamp to parameter maxima. Uses im2col_pkg.
module im2col_address_generator_core import im2col_pkg::*; #(
  parameter int MAX_DIM      = 4095,
  parameter int MAX_KERNEL   = 16,
  parameter int MAX_CHANNELS = 1024,
  parameter int MAX_BATCH    = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] restart, [7:1] zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [87:0]           m_tdata,   // [39:0] source_index, [87:40] column_index
  output logic                  m_tuser,   // [0] is_padding
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [REG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [23:0]   input_size;
  logic [23:0]   output_size;
  logic [9:0]    kernel_size;
  logic [9:0]    stride;
  logic [9:0]    padding;
  logic [9:0]    dilation;
  logic [10:0]   channels;
  logic [6:0]    batch;

  geom_t            geom;
  logic             push;
  elem_t            elem;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  elem_t            q_head;
  logic [SRC_W-1:0] source_index;
  logic [CNT_W-1:0] column_index;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_size  <= 24'd4097;
      output_size <= 24'd4097;
      kernel_size <= 10'd33;
      stride      <= 10'd33;
      padding     <= 10'd0;
      dilation    <= 10'd33;
      channels    <= 11'd1;
      batch       <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INPUT_SIZE:  input_size  <= cfg_data[23:0];
        REG_OUTPUT_SIZE: output_size <= cfg_data[23:0];
        REG_KERNEL_SIZE: kernel_size <= cfg_data[9:0];
        REG_STRIDE:      stride      <= cfg_data[9:0];
        REG_PADDING:     padding     <= cfg_data[9:0];
        REG_DILATION:    dilation    <= cfg_data[9:0];
        REG_CHANNELS:    channels    <= cfg_data[10:0];
        REG_BATCH:       batch       <= cfg_data[6:0];
      endcase
    end
  end

  always_comb begin
    geom.ih = clamp_val(input_size[23:12], CLAMP_W'(MAX_DIM));
    geom.iw = clamp_val(input_size[11:0], CLAMP_W'(MAX_DIM));
    geom.oh = clamp_val(output_size[23:12], CLAMP_W'(MAX_DIM));
    geom.ow = clamp_val(output_size[11:0], CLAMP_W'(MAX_DIM));
    geom.kh = LIM_K_W'(clamp_val(CLAMP_W'(kernel_size[9:5]), CLAMP_W'(MAX_KERNEL)));
    geom.kw = LIM_K_W'(clamp_val(CLAMP_W'(kernel_size[4:0]), CLAMP_W'(MAX_KERNEL)));
    geom.nc = LIM_C_W'(clamp_val(CLAMP_W'(channels), CLAMP_W'(MAX_CHANNELS)));
    geom.nb = LIM_B_W'(clamp_val(CLAMP_W'(batch), CLAMP_W'(MAX_BATCH)));
    geom.sv = stride[9:5];
    geom.sh = stride[4:0];
    geom.pt = padding[9:5];
    geom.pl = padding[4:0];
    geom.dv = dilation[9:5];
    geom.dh = dilation[4:0];
  end

  im2col_front u_front (
    .clk      (clk),
    .rst      (rst),
    .geom     (geom),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .restart  (s_tdata[0]),
    .q_full   (q_full),
    .push     (push),
    .elem     (elem)
  );

  im2col_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (elem),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_head)
  );

  im2col_back u_back (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .q_valid      (q_valid),
    .q_data       (q_head),
    .q_pop        (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .source_index (source_index),
    .is_padding   (m_tuser),
    .column_index (column_index),
    .last         (m_tlast)
  );

  assign m_tdata = {column_index, source_index};

  // A padded element never carries a source index.
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[SRC_W-1:0] == '0)
    else $error("padded element with nonzero source index");

  // The address pipeline only takes from the queue when it holds a position.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // A beat that stalls at the output keeps the queue from draining.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !q_pop)
    else $error("queue drained while the output is stalled");

endmodule
